// ----- rtl/lrubt_pkg.sv -----
// ----------------------------------------------------------------------------
// lrubt_pkg
// Shared constants, codes and beat types of the LRU register binding table.
// ----------------------------------------------------------------------------
package lrubt_pkg;

  localparam int NUM_SLOTS  = 7;
  localparam int ID_WIDTH   = 16;
  localparam int ADDR_WIDTH = 16;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int REG_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int MODE_W     = 2;

  localparam logic [REG_W-1:0]      REG_BASE         = REG_W'(2);
  localparam logic [ADDR_WIDTH-1:0] NEAR_LIMIT_RESET = ADDR_WIDTH'(50);

  // Operation codes.
  localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MARK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_KEEP  = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_HIT        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FREE_FILL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REPLACED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MARKED     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FLUSH      = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [ID_WIDTH-1:0]   var_id;
    logic [ADDR_WIDTH-1:0] var_addr;
    logic                  real_load;
    logic                  quiet;
    logic                  skip_local;
  } in_t;

  typedef struct packed {
    logic [REG_W-1:0]      reg_num;
    logic [STATUS_W-1:0]   status;
    logic                  fill_valid;
    logic [ADDR_WIDTH-1:0] fill_addr;
    logic                  fill_far;
    logic                  writeback_valid;
    logic [REG_W-1:0]      writeback_reg;
    logic [ADDR_WIDTH-1:0] writeback_addr;
    logic                  writeback_far;
    logic                  scratch_preserve;
    logic                  last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;         // capture the input beat
    logic single;       // run a load or mark and emit its one result
    logic flush_start;  // snapshot the entries to be written back
    logic flush_step;   // examine one age, emit a beat if an entry has it
    logic flush_end;    // finish a flush, emptying the table on clear
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_flush;
    logic out_free;
    logic pending_empty;
  } stat_t;

endpackage

// ----- rtl/lru_register_binding_table.sv -----
// ----------------------------------------------------------------------------
// lru_register_binding_table
// Fully associative LRU table binding variable ids to working registers.
// ----------------------------------------------------------------------------
// A load or mark-dirty beat is first captured and then given the parallel
// tag match, LRU update and result, which waits only while the output
// register is held by a stalled beat. Clear and flush-keep capture the beat,
// snapshot the entries to be written back, take one scan step per age up to
// the oldest entry written back and then finish; the age scan emits at most
// one writeback beat per step, youngest entry first. No new beat is accepted
// until the current one has finished.
module lru_register_binding_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [lrubt_pkg::ADDR_WIDTH-1:0] cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lrubt_pkg::in_t                   in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lrubt_pkg::out_t                  out_data
);
  import lrubt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lrubt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  lrubt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Once a beat is taken, the input stays closed while it is worked on.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a beat was in progress");

  // A load or mark always produces one final result beat.
  assert property (@(posedge clk) disable iff (rst)
    cmd.single |=> (out_valid && out_data.last))
    else $error("single operation did not present a final result");

  // Every flush beat carries a writeback.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ST_FLUSH)) |-> out_data.writeback_valid)
    else $error("flush beat without writeback");

endmodule

// ----- rtl/lrubt_ctrl.sv -----
// ----------------------------------------------------------------------------
// lrubt_ctrl
// Sequencer: captures a beat, runs a single lookup or steps a flush scan.
// ----------------------------------------------------------------------------
module lrubt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lrubt_pkg::stat_t stat,
  output lrubt_pkg::cmd_t  cmd
);
  import lrubt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_flush) begin
          cmd.flush_start = 1'b1;
          state_next      = S_FLUSH;
        end else if (stat.out_free) begin
          cmd.single = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (stat.pending_empty) begin
          cmd.flush_end = 1'b1;
          state_next    = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush_step = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lrubt_datapath.sv -----
// ----------------------------------------------------------------------------
// lrubt_datapath
// Slot table, tag match, LRU ages, flush scan and the output register.
// ----------------------------------------------------------------------------
module lrubt_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lrubt_pkg::ADDR_WIDTH-1:0]  cfg_wdata,
  input  lrubt_pkg::in_t                    in_data,
  output lrubt_pkg::out_t                   out_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  lrubt_pkg::cmd_t                   cmd,
  output lrubt_pkg::stat_t                  stat
);
  import lrubt_pkg::*;

  logic [ADDR_WIDTH-1:0] near_limit;
  in_t                   item;

  logic [NUM_SLOTS-1:0]  slot_valid;
  logic [NUM_SLOTS-1:0]  slot_dirty;
  logic [SLOT_W-1:0]     slot_age  [NUM_SLOTS];
  logic [ID_WIDTH-1:0]   slot_var  [NUM_SLOTS];
  logic [ADDR_WIDTH-1:0] slot_addr [NUM_SLOTS];

  logic [NUM_SLOTS-1:0]  pending;
  logic [SLOT_W-1:0]     flush_age;

  logic [NUM_SLOTS-1:0]  slot_far;
  logic [NUM_SLOTS-1:0]  qualify;
  logic [NUM_SLOTS-1:0]  match;
  logic                  hit;
  logic                  any_free;
  logic                  match_any;
  logic [SLOT_W-1:0]     hit_slot;
  logic [SLOT_W-1:0]     free_slot;
  logic [SLOT_W-1:0]     victim_slot;
  logic [SLOT_W-1:0]     flush_slot;
  logic [SLOT_W-1:0]     sel_slot;
  logic                  only_far;
  logic                  out_load;
  out_t                  out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      near_limit <= NEAR_LIMIT_RESET;
    end else if (cfg_we) begin
      near_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= in_data;
    end
  end

  // Per-slot match, free and victim search; the lowest index wins except for
  // the victim, where the highest index holding the oldest age wins.
  always_comb begin
    hit         = 1'b0;
    any_free    = 1'b0;
    match_any   = 1'b0;
    hit_slot    = '0;
    free_slot   = '0;
    victim_slot = '0;
    flush_slot  = '0;
    only_far    = (item.mode == MODE_CLEAR) && item.skip_local;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      slot_far[i] = slot_addr[i] > near_limit;
      qualify[i]  = slot_valid[i] && slot_dirty[i] && (!only_far || slot_far[i]);
      match[i]    = pending[i] && (slot_age[i] == flush_age);
      if (slot_valid[i] && (slot_var[i] == item.var_id)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
      if (!slot_valid[i]) begin
        any_free  = 1'b1;
        free_slot = SLOT_W'(i);
      end
      if (match[i]) begin
        match_any  = 1'b1;
        flush_slot = SLOT_W'(i);
      end
    end
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_age[i] == SLOT_W'(NUM_SLOTS - 1)) begin
        victim_slot = SLOT_W'(i);
      end
    end
    priority if (hit) begin
      sel_slot = hit_slot;
    end else if (any_free) begin
      sel_slot = free_slot;
    end else begin
      sel_slot = victim_slot;
    end
  end

  // Slot control state: valid, dirty and age.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_dirty <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_age[i] <= '0;
      end
    end else if (cmd.single && (item.mode == MODE_LOAD)) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (SLOT_W'(i) == sel_slot) begin
          slot_age[i] <= '0;
        end else if (slot_valid[i] && (!hit || (slot_age[i] < slot_age[sel_slot]))) begin
          slot_age[i] <= slot_age[i] + SLOT_W'(1);
        end
      end
      if (!hit) begin
        slot_valid[sel_slot] <= 1'b1;
        slot_dirty[sel_slot] <= 1'b0;
      end
    end else if (cmd.single && (item.mode == MODE_MARK) && hit) begin
      slot_dirty[hit_slot] <= 1'b1;
    end else if (cmd.flush_end && (item.mode == MODE_CLEAR)) begin
      slot_valid <= '0;
      slot_dirty <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_age[i] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.single && (item.mode == MODE_LOAD) && !hit) begin
      slot_var[sel_slot]  <= item.var_id;
      slot_addr[sel_slot] <= item.var_addr;
    end
  end

  // Flush scan: one age per step, youngest first.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      flush_age <= '0;
    end else if (cmd.flush_start) begin
      pending   <= qualify;
      flush_age <= '0;
    end else if (cmd.flush_step) begin
      pending   <= pending & ~match;
      flush_age <= flush_age + SLOT_W'(1);
    end
  end

  always_comb begin
    out_next = '0;
    if (cmd.flush_step) begin
      out_next.reg_num         = REG_W'(flush_slot) + REG_BASE;
      out_next.status          = ST_FLUSH;
      out_next.writeback_valid = 1'b1;
      out_next.writeback_reg   = REG_W'(flush_slot) + REG_BASE;
      out_next.writeback_addr  = slot_addr[flush_slot];
      out_next.writeback_far   = slot_far[flush_slot];
      out_next.last            = (pending & ~match) == '0;
    end else if (item.mode == MODE_LOAD) begin
      out_next.reg_num = REG_W'(sel_slot) + REG_BASE;
      out_next.last    = 1'b1;
      priority if (hit) begin
        out_next.status = ST_HIT;
      end else if (any_free) begin
        out_next.status = ST_FREE_FILL;
      end else begin
        out_next.status = ST_REPLACED;
      end
      if (!hit) begin
        out_next.fill_valid = item.real_load;
        out_next.fill_addr  = item.real_load ? item.var_addr : '0;
        out_next.fill_far   = item.real_load && (item.var_addr > near_limit);
        if (!any_free && slot_dirty[victim_slot]) begin
          out_next.writeback_valid = 1'b1;
          out_next.writeback_reg   = REG_W'(victim_slot) + REG_BASE;
          out_next.writeback_addr  = slot_addr[victim_slot];
          out_next.writeback_far   = slot_far[victim_slot];
        end
      end
      out_next.scratch_preserve = item.quiet &&
                                  (out_next.fill_far || out_next.writeback_far);
    end else begin
      out_next.last = 1'b1;
      if (hit) begin
        out_next.reg_num = REG_W'(hit_slot) + REG_BASE;
        out_next.status  = ST_MARKED;
      end else begin
        out_next.status  = ST_NOT_LOADED;
      end
    end
  end

  // A step that finds no entry at its age emits nothing.
  assign out_load = cmd.single || (cmd.flush_step && match_any);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  assign stat.is_flush      = (item.mode == MODE_CLEAR) || (item.mode == MODE_KEEP);
  assign stat.out_free      = !out_valid || !out_stall;
  assign stat.pending_empty = pending == '0;

endmodule
